// ===== hdl/bmprle_pkg.sv =====
// Shared types and codes of the bitmap RLE decoder.
package bmprle_pkg;

	// Fixed widths of the result fields.
	localparam int COORD_W = 16;
	localparam int CNT_W   = 8;

	// Record phase of the byte-stream parser.
	typedef enum logic [2:0] {
		PH_COUNT = 3'd0,
		PH_VALUE = 3'd1,
		PH_ESC   = 3'd2,
		PH_DX    = 3'd3,
		PH_DY    = 3'd4,
		PH_ABS   = 3'd5,
		PH_PAD   = 3'd6,
		PH_DONE  = 3'd7
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_SEGMENT = 2'd0,
		KIND_EOL     = 2'd1,
		KIND_EOB     = 2'd2,
		KIND_DELTA   = 2'd3
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_RLE4   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	// Parser control state that does not depend on the image dimensions.
	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] held_count;
		logic [CNT_W-1:0] absolute_left;
		logic             absolute_odd;
	} ctl_t;

	// Result fields that do not depend on the image dimensions.
	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] pixel_count;
		logic [7:0]       pattern_byte;
		logic             finished;
	} res_t;

endpackage

// ===== hdl/bmprle_step.sv =====
// Next-state and result logic for one compressed byte.
module bmprle_step
	import bmprle_pkg::*;
#(
	parameter int DIM_BITS = 16
) (
	input  logic                       rle4_mode,
	input  logic [DIM_BITS-1:0]        image_width,
	input  logic [DIM_BITS-1:0]        image_height,
	input  logic [7:0]                 data_byte,
	input  logic                       start_of_image,
	input  ctl_t                       ctl_cur,
	input  logic [DIM_BITS:0]          col_cur,
	input  logic signed [DIM_BITS+1:0] row_cur,
	output ctl_t                       ctl_nxt,
	output logic [DIM_BITS:0]          col_nxt,
	output logic signed [DIM_BITS+1:0] row_nxt,
	output logic                       res_valid,
	output res_t                       res,
	output logic [DIM_BITS-1:0]        res_row,
	output logic [DIM_BITS-1:0]        res_col
);

	localparam int CW = DIM_BITS + 1;
	localparam int RW = DIM_BITS + 2;

	ctl_t                 ctl_eff;
	logic [CW-1:0]        col_eff;
	logic signed [RW-1:0] row_eff;
	logic signed [RW-1:0] row_start;
	logic signed [RW-1:0] byte_ext;
	logic signed [RW-1:0] row_minus;
	logic [CW-1:0]        width_ext;
	logic [CW-1:0]        room;
	logic [CW-1:0]        col_delta;
	logic [CNT_W-1:0]     run_n;
	logic [CNT_W-1:0]     abs_n;
	logic [CNT_W-1:0]     take;
	logic [CNT_W-1:0]     abs_left_nxt;
	logic                 fin;

	// A restart reloads the pen before the byte is taken.
	assign row_start = RW'(image_height) - RW'(1);
	always_comb begin
		if (start_of_image) begin
			ctl_eff.phase         = row_start[RW-1] ? PH_DONE : PH_COUNT;
			ctl_eff.held_count    = '0;
			ctl_eff.absolute_left = '0;
			ctl_eff.absolute_odd  = 1'b0;
			col_eff               = '0;
			row_eff               = row_start;
		end else begin
			ctl_eff = ctl_cur;
			col_eff = col_cur;
			row_eff = row_cur;
		end
	end

	assign width_ext = CW'(image_width);
	assign room      = width_ext - col_eff;
	assign byte_ext  = signed'(RW'(data_byte));
	assign col_delta = col_eff + CW'(ctl_eff.held_count);

	// Pixels of an absolute data byte: one, or up to two in four-bit mode.
	always_comb begin
		if (rle4_mode && (ctl_eff.absolute_left >= CNT_W'(2))) begin
			abs_n = CNT_W'(2);
		end else if (rle4_mode) begin
			abs_n = ctl_eff.absolute_left;
		end else begin
			abs_n = (ctl_eff.absolute_left != '0) ? CNT_W'(1) : '0;
		end
	end
	assign abs_left_nxt = ctl_eff.absolute_left - abs_n;
	assign run_n = (ctl_eff.phase == PH_ABS) ? abs_n : ctl_eff.held_count;

	// Clip the run at the right edge of the row.
	always_comb begin
		if (col_eff >= width_ext) begin
			take = '0;
		end else if (CW'(run_n) > room) begin
			take = room[CNT_W-1:0];
		end else begin
			take = run_n;
		end
	end

	always_comb begin
		ctl_nxt          = ctl_eff;
		col_nxt          = col_eff;
		row_nxt          = row_eff;
		res_valid        = 1'b0;
		res.kind         = KIND_SEGMENT;
		res.pixel_count  = '0;
		res.pattern_byte = '0;
		res.finished     = 1'b0;
		row_minus        = row_eff - RW'(1);
		fin              = 1'b0;
		case (ctl_eff.phase)
			PH_COUNT: begin
				if (data_byte != 8'd0) begin
					ctl_nxt.held_count = data_byte;
					ctl_nxt.phase      = PH_VALUE;
				end else begin
					ctl_nxt.phase = PH_ESC;
				end
			end
			PH_VALUE: begin
				res_valid        = 1'b1;
				res.pixel_count  = take;
				res.pattern_byte = data_byte;
				col_nxt          = col_eff + CW'(take);
				ctl_nxt.phase    = PH_COUNT;
			end
			PH_ESC: begin
				if (data_byte == 8'd0) begin
					fin           = row_minus[RW-1];
					row_nxt       = row_minus;
					col_nxt       = '0;
					res_valid     = 1'b1;
					res.kind      = KIND_EOL;
					res.finished  = fin;
					ctl_nxt.phase = fin ? PH_DONE : PH_COUNT;
				end else if (data_byte == 8'd1) begin
					res_valid     = 1'b1;
					res.kind      = KIND_EOB;
					res.finished  = 1'b1;
					ctl_nxt.phase = PH_DONE;
				end else if (data_byte == 8'd2) begin
					ctl_nxt.phase = PH_DX;
				end else begin
					ctl_nxt.absolute_left = data_byte;
					ctl_nxt.absolute_odd  = 1'b0;
					ctl_nxt.phase         = PH_ABS;
				end
			end
			PH_DX: begin
				ctl_nxt.held_count = data_byte;
				ctl_nxt.phase      = PH_DY;
			end
			PH_DY: begin
				row_minus     = row_eff - byte_ext;
				fin           = row_minus[RW-1] || (col_delta > width_ext);
				row_nxt       = row_minus;
				col_nxt       = col_delta;
				res_valid     = 1'b1;
				res.kind      = KIND_DELTA;
				res.finished  = fin;
				ctl_nxt.phase = fin ? PH_DONE : PH_COUNT;
			end
			PH_ABS: begin
				res_valid             = 1'b1;
				res.pixel_count       = take;
				res.pattern_byte      = data_byte;
				col_nxt               = col_eff + CW'(take);
				ctl_nxt.absolute_left = abs_left_nxt;
				ctl_nxt.absolute_odd  = ~ctl_eff.absolute_odd;
				if (abs_left_nxt == '0) begin
					ctl_nxt.phase = ctl_eff.absolute_odd ? PH_COUNT : PH_PAD;
				end
			end
			PH_PAD: begin
				ctl_nxt.phase = PH_COUNT;
			end
			default: begin
				ctl_nxt.phase = PH_DONE;
			end
		endcase
	end

	assign res_row = row_eff[DIM_BITS-1:0];
	assign res_col = col_eff[DIM_BITS-1:0];

endmodule

// ===== hdl/bitmap_rle_decoder.sv =====
// Top level of the bitmap RLE4 / RLE8 byte-stream decoder.
//
// Compressed bitmap bytes enter on the input channel (in_valid, in_stall,
// data_byte, start_of_image), one byte per transfer. Decoded records leave
// on the output channel (out_valid, out_stall and the result fields): pixel
// segments clipped at the image width, end of line, end of bitmap and delta
// moves. Count, escape, length, dx and pad bytes produce no result.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes rle4_mode, image_width and image_height; cfg_ready is always high.
// A new height takes effect at the next byte flagged start_of_image; the
// pixel mode and the width apply to the next byte that is decoded.
// Each byte is captured in an input register and decoded from there into
// the output register once that register can take it. One byte per cycle
// is sustained while the receiver does not stall: the input register
// moves on whenever the output register is empty or being emptied.
// When the receiver stalls, the held result stays put, the input register
// fills and then in_stall rises. Reset clears both registers and loads the
// power-on image (eight-bit pixels, one by one pixel) at its bottom row.
// After end of bitmap or a pen move off the image, bytes are consumed
// without results until start_of_image restarts decoding.
module bitmap_rle_decoder
	import bmprle_pkg::*;
#(
	parameter int DIM_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                start_of_image,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [COORD_W-1:0]  row,
	output logic [COORD_W-1:0]  start_column,
	output logic [CNT_W-1:0]    pixel_count,
	output logic [7:0]          pattern_byte,
	output logic                finished,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [DIM_BITS-1:0] cfg_data
);

	localparam int CW = DIM_BITS + 1;
	localparam int RW = DIM_BITS + 2;

	// Configuration registers.
	logic                rle4_q;
	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;

	// Decoder state.
	ctl_t                 ctl_q;
	logic [CW-1:0]        col_q;
	logic signed [RW-1:0] row_q;

	// Step outputs.
	ctl_t                 ctl_d;
	logic [CW-1:0]        col_d;
	logic signed [RW-1:0] row_d;
	logic                 res_valid;
	res_t                 res;
	logic [DIM_BITS-1:0]  res_row;
	logic [DIM_BITS-1:0]  res_col;

	logic advance;
	logic load_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle4_q   <= 1'b0;
			width_q  <= DIM_BITS'(1);
			height_q <= DIM_BITS'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RLE4:   rle4_q   <= cfg_data[0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The byte in the input register is decoded when the output register
	// is free to take whatever it produces.
	assign advance  = !out_valid || !out_stall;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_image;
		end
	end

	bmprle_step #(
		.DIM_BITS(DIM_BITS)
	) u_step (
		.rle4_mode      (rle4_q),
		.image_width    (width_q),
		.image_height   (height_q),
		.data_byte      (byte_s1),
		.start_of_image (sof_s1),
		.ctl_cur        (ctl_q),
		.col_cur        (col_q),
		.row_cur        (row_q),
		.ctl_nxt        (ctl_d),
		.col_nxt        (col_d),
		.row_nxt        (row_d),
		.res_valid      (res_valid),
		.res            (res),
		.res_row        (res_row),
		.res_col        (res_col)
	);

	// Reset state matches a restart with a one-row image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase         <= PH_COUNT;
			ctl_q.held_count    <= '0;
			ctl_q.absolute_left <= '0;
			ctl_q.absolute_odd  <= 1'b0;
			col_q               <= '0;
			row_q               <= '0;
		end else if (valid_s1 && advance) begin
			ctl_q <= ctl_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			kind         <= res.kind;
			row          <= COORD_W'(res_row);
			start_column <= COORD_W'(res_col);
			pixel_count  <= res.pixel_count;
			pattern_byte <= res.pattern_byte;
			finished     <= res.finished;
		end
	end

	// A pixel segment never ends decoding.
	a_segment_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_SEGMENT) |-> !finished)
		else $error("pixel segment flagged as finished");

	// Once stopped, only a restart resumes decoding.
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && (ctl_q.phase == PH_DONE) && !sof_s1
		|=> ctl_q.phase == PH_DONE)
		else $error("decoder left the stopped phase without a restart");

	// While decoding, the pen row is never below the bottom of the image.
	a_row_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.phase != PH_DONE) |-> !row_q[RW-1])
		else $error("pen row negative while decoding");

	// A byte waiting on a full output register is kept.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(sof_s1))
		else $error("input register lost a byte during a stall");

endmodule
